FILE: src/gfm_pkg.sv
// Shared constants, codes and types for the gated frequency monitor.
package gfm_pkg;

  localparam int unsigned RawBits    = 16;
  localparam int unsigned LowWidth   = 16;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned WrapBits   = CountWidth - RawBits;
  localparam int unsigned GateWidth  = 32;
  localparam int unsigned HzWidth    = 29;
  localparam int unsigned FreqWidth  = 32;
  localparam int unsigned ProdWidth  = CountWidth + HzWidth;
  localparam int unsigned DivSteps   = ProdWidth;
  localparam int unsigned DivCntWidth = $clog2(DivSteps + 1);
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = HzWidth;

  localparam logic [HzWidth-1:0] GateClockHzReset = HzWidth'(250000000);

  localparam logic [CfgIdxWidth-1:0] CfgMonitorEnable = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CfgGateClockHz   = CfgIdxWidth'(1);

  localparam logic OpWrap   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: src/gated_frequency_monitor.sv
// Gated frequency monitor: sample sequencer, window check and serial divider.
// Wrap event: advances the wrap count, no result.
// Recording or disabled sample: straight to result; window failure: check, then result.
// Measured sample: check, multiply, then the 61-step serial divider before the result.
// One transaction at a time: input ready from the edge that registers the result.
// Asynchronous active-low reset clears all state; gate clock register resets to 250 MHz.
module gated_frequency_monitor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gfm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [gfm_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [gfm_pkg::LowWidth-1:0]       counter_low_i,
  input  logic                               overflow_pending_i,
  input  logic [gfm_pkg::GateWidth-1:0]      gate_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [gfm_pkg::FreqWidth-1:0]      frequency_hz_o,
  output logic                               frequency_valid_o,
  output logic                               edges_present_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StMul,
    StDiv,
    StResult
  } state_e;

  state_e                            state_q;
  logic                              enable_q;
  logic [gfm_pkg::HzWidth-1:0]       hz_q;
  logic [gfm_pkg::WrapBits-1:0]      wrap_q;
  logic [gfm_pkg::CountWidth-1:0]    prev_count_q;
  logic [gfm_pkg::GateWidth-1:0]     prev_gate_q;
  logic                              have_prev_q;
  logic [gfm_pkg::CountWidth-1:0]    d_count_q;
  logic [gfm_pkg::GateWidth-1:0]     d_gate_q;
  logic [gfm_pkg::ProdWidth-1:0]     prod_q;
  logic                              div_start_q;
  logic [gfm_pkg::FreqWidth-1:0]     meas_freq_q;
  logic                              meas_valid_q;
  logic                              edges_q;
  logic                              out_valid_q;
  logic [gfm_pkg::FreqWidth-1:0]     out_freq_q;
  logic                              out_fvalid_q;
  logic                              out_edges_q;

  logic [gfm_pkg::RawBits-1:0]       raw_cnt;
  logic [gfm_pkg::WrapBits-1:0]      wraps;
  logic [gfm_pkg::CountWidth-1:0]    ext_count;
  logic                              accept;
  logic                              active;
  logic [gfm_pkg::GateWidth+3:0]     gate_min;
  logic                              gate_bad;
  logic [gfm_pkg::ProdWidth-1:0]     quotient;
  gfm_pkg::div_sts_t                 div_sts;

  assign accept  = in_valid_i && in_ready_o;
  assign active  = enable_q && (hz_q != '0);
  assign raw_cnt = gfm_pkg::RawBits'(counter_low_i);
  assign wraps   = wrap_q + gfm_pkg::WrapBits'(overflow_pending_i
                   && !raw_cnt[gfm_pkg::RawBits-1]);
  assign ext_count = {wraps, raw_cnt};

  // gate < hz/10 holds exactly when 10*gate + 10 <= hz
  assign gate_min = {1'b0, d_gate_q, 3'b000} + {3'b000, d_gate_q, 1'b0}
                    + (gfm_pkg::GateWidth + 4)'(10);
  assign gate_bad = (d_gate_q == '0)
                    || (gate_min <= (gfm_pkg::GateWidth + 4)'(hz_q))
                    || (d_gate_q > {hz_q, 3'b000});

  gfm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_q),
    .divisor_i  (d_gate_q),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      enable_q     <= 1'b0;
      hz_q         <= gfm_pkg::GateClockHzReset;
      wrap_q       <= '0;
      prev_count_q <= '0;
      prev_gate_q  <= '0;
      have_prev_q  <= 1'b0;
      d_count_q    <= '0;
      d_gate_q     <= '0;
      prod_q       <= '0;
      div_start_q  <= 1'b0;
      meas_freq_q  <= '0;
      meas_valid_q <= 1'b0;
      edges_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_freq_q   <= '0;
      out_fvalid_q <= 1'b0;
      out_edges_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gfm_pkg::CfgMonitorEnable: enable_q <= cfg_data_i[0];
          gfm_pkg::CfgGateClockHz:   hz_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != StResult)) begin
        out_valid_q <= 1'b0;
      end
      div_start_q <= state_q == StMul;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (operation_i == gfm_pkg::OpWrap) begin
              wrap_q <= wrap_q + gfm_pkg::WrapBits'(1);
            end else if (!active) begin
              state_q <= StResult;
            end else begin
              prev_count_q <= ext_count;
              prev_gate_q  <= gate_count_i;
              have_prev_q  <= 1'b1;
              d_count_q    <= ext_count - prev_count_q;
              d_gate_q     <= gate_count_i - prev_gate_q;
              state_q      <= have_prev_q ? StCheck : StResult;
            end
          end
        end
        StCheck: begin
          if (gate_bad) begin
            meas_valid_q <= 1'b0;
            state_q      <= StResult;
          end else begin
            edges_q <= d_count_q != '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= d_count_q * hz_q;
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_sts.done) begin
            meas_freq_q  <= quotient[gfm_pkg::FreqWidth-1:0];
            meas_valid_q <= 1'b1;
            state_q      <= StResult;
          end
        end
        StResult: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_freq_q   <= meas_freq_q;
            out_fvalid_q <= meas_valid_q;
            out_edges_q  <= edges_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o        = state_q == StIdle;
  assign out_valid_o       = out_valid_q;
  assign frequency_hz_o    = out_freq_q;
  assign frequency_valid_o = out_fvalid_q;
  assign edges_present_o   = out_edges_q;

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == StDiv)
    else $error("divider finished outside the divide state");

  a_idle_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_sts.busy)
    else $error("input ready while divider busy");

  a_wrap_incr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == gfm_pkg::OpWrap)
    |=> wrap_q == $past(wrap_q) + gfm_pkg::WrapBits'(1))
    else $error("wrap transaction did not advance the wrap count");

  a_valid_from_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(meas_valid_q) |-> $past(state_q) == StDiv)
    else $error("measurement marked valid without a division");

endmodule

FILE: src/gfm_divider.sv
// Serial restoring divider, one quotient bit per cycle.
module gfm_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [gfm_pkg::ProdWidth-1:0]       dividend_i,
  input  logic [gfm_pkg::GateWidth-1:0]       divisor_i,
  output logic [gfm_pkg::ProdWidth-1:0]       quotient_o,
  output gfm_pkg::div_sts_t                   sts_o
);

  logic [gfm_pkg::GateWidth-1:0]   rem_q, rem_d;
  logic [gfm_pkg::GateWidth-1:0]   div_q;
  logic [gfm_pkg::ProdWidth-1:0]   quo_q;
  logic [gfm_pkg::DivCntWidth-1:0] cnt_q;
  logic                            done_q;
  logic [gfm_pkg::GateWidth:0]     trial;
  logic [gfm_pkg::GateWidth:0]     diff;
  logic                            ge;

  assign trial = {rem_q, quo_q[gfm_pkg::ProdWidth-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};
  assign rem_d = ge ? diff[gfm_pkg::GateWidth-1:0] : trial[gfm_pkg::GateWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == gfm_pkg::DivCntWidth'(1));
      if (start_i) begin
        cnt_q <= gfm_pkg::DivCntWidth'(gfm_pkg::DivSteps);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - gfm_pkg::DivCntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[gfm_pkg::ProdWidth-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = cnt_q != '0;
  assign sts_o.done = done_q;

endmodule
